// File: rtl/mf2_pkg.sv
// Shared types, sizes and codes for the 2-D median filter.
// No dependencies; the RTL files but mf2_ram refer to it by scoped names, the bench files import it.
package mf2_pkg;

  // Frame and window geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_RADIUS  = 2;
  localparam int MAX_HEIGHT  = 4095;
  localparam int MIN_DIM     = 5;
  localparam int WIN_SIDE    = 2 * MAX_RADIUS + 1;
  localparam int WIN_SIZE    = WIN_SIDE * WIN_SIDE;
  localparam int HIST_ROWS   = 2 * MAX_RADIUS;
  localparam int PIX_W       = 24;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int WIDTH_CFG_W = 11;
  localparam int D_W         = 12;
  localparam int RANK_W      = $clog2(WIN_SIZE + 1);

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Queues
  localparam int QDEPTH = 4;
  localparam int QP_W   = $clog2(QDEPTH);
  localparam int ODEPTH = 8;
  localparam int OP_W   = $clog2(ODEPTH);

  // Centre taps and median ranks of the two window sizes
  localparam int CENTRE5 = (WIN_SIDE - 3) * (WIN_SIDE + 1);
  localparam int CENTRE3 = (WIN_SIDE - 2) * (WIN_SIDE + 1);
  localparam int RANK5   = WIN_SIZE / 2;
  localparam int RANK3   = 9 / 2;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_SIZE-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic mode5;
    logic interior;
    logic row_end;
    logic frame_end;
  } tag_t;

  typedef struct packed {
    pix_t              value;
    logic [COL_W-1:0]  col;
    logic              emit;
    tag_t              tag;
  } cmd_t;

  typedef struct packed {
    pix_t pixel;
    logic row_end;
    logic frame_end;
  } res_t;

  // Window tap idx takes part in the median of the selected window size
  function automatic logic in_sub(input int idx, input logic mode5);
    return mode5 || (((idx / WIN_SIDE) >= WIN_SIDE - 3) && ((idx % WIN_SIDE) >= WIN_SIDE - 3));
  endfunction

endpackage

// File: rtl/mf2_stream_if.sv
// Valid/ready stream interfaces for the pixel input and the result output.
// Depends on mf2_pkg.
interface mf2_in_if;
  logic                 valid;
  logic                 ready;
  mf2_pkg::op_t         operation;
  logic [mf2_pkg::PIX_W-1:0] pixel_in;
  modport source (output valid, operation, pixel_in, input ready);
  modport sink   (input valid, operation, pixel_in, output ready);
endinterface

interface mf2_out_if;
  logic                 valid;
  logic                 ready;
  logic [mf2_pkg::PIX_W-1:0] pixel_out;
  logic                 row_end;
  logic                 frame_end;
  modport source (output valid, pixel_out, row_end, frame_end, input ready);
  modport sink   (input valid, pixel_out, row_end, frame_end, output ready);
endinterface

// File: rtl/mf2_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mf2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/mf2_front.sv
// Front end: configuration registers, raster position counters and command queue.
// Classifies each item into a window push and/or a result. Depends on mf2_pkg, mf2_stream_if.
module mf2_front (
  input  logic                           clk,
  input  logic                           rst_n,
  mf2_in_if.sink                         in_chan,
  input  logic                           cfg_we,
  input  logic [mf2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf2_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           cmd_pop,
  output logic                           cmd_valid,
  output mf2_pkg::cmd_t                  cmd_head
);
  logic [mf2_pkg::WIDTH_CFG_W-1:0] width_r, width_nxt;
  logic [mf2_pkg::ROW_W-1:0]       height_r, height_nxt;
  logic                            mode_r, mode_nxt;
  logic [mf2_pkg::WIDTH_CFG_W-1:0] w_eff_r, w_eff_nxt;
  logic [mf2_pkg::ROW_W-1:0]       h_eff_r, h_eff_nxt;
  logic [mf2_pkg::D_W-1:0]         d_r, d_nxt;
  logic                            mode5_r;

  logic [mf2_pkg::COL_W-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [mf2_pkg::ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [mf2_pkg::D_W-1:0]   pend_r, pend_nxt, pend_inc;

  logic accept, complete, in_last, is_pix, drain_ok, push, emit;
  logic out_row_end, out_frame_end, interior;
  mf2_pkg::cmd_t cmd;

  mf2_pkg::cmd_t            q_mem_r [mf2_pkg::QDEPTH];
  logic [mf2_pkg::QP_W-1:0] q_wr_r, q_rd_r;
  logic [mf2_pkg::QP_W:0]   q_cnt_r;

  // Take the written value of each configuration register
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    mode_nxt   = mode_r;
    if (cfg_we) begin
      if (cfg_index == mf2_pkg::CFG_WIDTH) begin
        width_nxt = cfg_data[mf2_pkg::WIDTH_CFG_W-1:0];
      end
      if (cfg_index == mf2_pkg::CFG_HEIGHT) begin
        height_nxt = cfg_data[mf2_pkg::ROW_W-1:0];
      end
      if (cfg_index == mf2_pkg::CFG_MODE) begin
        mode_nxt = cfg_data[0];
      end
    end
  end

  // Capture configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mf2_pkg::WIDTH_CFG_W'(mf2_pkg::RESET_WIDTH);
      height_r <= mf2_pkg::ROW_W'(mf2_pkg::RESET_HEIGHT);
      mode_r   <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      mode_r   <= mode_nxt;
    end
  end

  // Clamp the geometry and work out the output delay
  always_comb begin
    if (width_nxt > mf2_pkg::WIDTH_CFG_W'(mf2_pkg::MAX_WIDTH)) begin
      w_eff_nxt = mf2_pkg::WIDTH_CFG_W'(mf2_pkg::MAX_WIDTH);
    end else if (width_nxt < mf2_pkg::WIDTH_CFG_W'(mf2_pkg::MIN_DIM)) begin
      w_eff_nxt = mf2_pkg::WIDTH_CFG_W'(mf2_pkg::MIN_DIM);
    end else begin
      w_eff_nxt = width_nxt;
    end
    if (height_nxt > mf2_pkg::ROW_W'(mf2_pkg::MAX_HEIGHT)) begin
      h_eff_nxt = mf2_pkg::ROW_W'(mf2_pkg::MAX_HEIGHT);
    end else if (height_nxt < mf2_pkg::ROW_W'(mf2_pkg::MIN_DIM)) begin
      h_eff_nxt = mf2_pkg::ROW_W'(mf2_pkg::MIN_DIM);
    end else begin
      h_eff_nxt = height_nxt;
    end
    if (mode_nxt && mf2_pkg::MAX_RADIUS > 1) begin
      d_nxt = {w_eff_nxt, 1'b0} + mf2_pkg::D_W'(2);
    end else begin
      d_nxt = mf2_pkg::D_W'(w_eff_nxt) + mf2_pkg::D_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_eff_r <= mf2_pkg::WIDTH_CFG_W'(mf2_pkg::RESET_WIDTH);
      h_eff_r <= mf2_pkg::ROW_W'(mf2_pkg::RESET_HEIGHT);
      d_r     <= mf2_pkg::D_W'(mf2_pkg::RESET_WIDTH + 1);
      mode5_r <= 1'b0;
    end else begin
      w_eff_r <= w_eff_nxt;
      h_eff_r <= h_eff_nxt;
      d_r     <= d_nxt;
      mode5_r <= mode_nxt && (mf2_pkg::MAX_RADIUS > 1);
    end
  end

  // Classify the item
  assign in_chan.ready = (q_cnt_r != (mf2_pkg::QP_W + 1)'(mf2_pkg::QDEPTH));
  assign accept   = in_chan.valid && in_chan.ready;
  assign complete = (in_row_r >= h_eff_r);
  assign in_last  = (mf2_pkg::WIDTH_CFG_W'(in_col_r) + 1'b1) >= w_eff_r;
  assign is_pix   = (in_chan.operation == mf2_pkg::OP_PIXEL) && !complete;
  assign drain_ok = !is_pix && complete && (pend_r != '0);
  assign pend_inc = pend_r + 1'b1;
  assign push     = is_pix || drain_ok;
  assign emit     = (is_pix && (pend_inc > d_r)) || drain_ok;

  // Position of the pixel about to leave
  always_comb begin
    logic [mf2_pkg::ROW_W:0]       orow_r;
    logic [mf2_pkg::WIDTH_CFG_W:0] ocol_r;
    orow_r = {1'b0, out_row_r} + (mf2_pkg::ROW_W + 1)'(mode5_r ? 2 : 1);
    ocol_r = {2'b0, out_col_r} + (mf2_pkg::WIDTH_CFG_W + 1)'(mode5_r ? 2 : 1);
    out_row_end   = (mf2_pkg::WIDTH_CFG_W'(out_col_r) + 1'b1) >= w_eff_r;
    out_frame_end = out_row_end && ((out_row_r + 1'b1) >= h_eff_r);
    interior = (out_row_r >= mf2_pkg::ROW_W'(mode5_r ? 2 : 1))
            && (orow_r < {1'b0, h_eff_r})
            && (out_col_r >= mf2_pkg::COL_W'(mode5_r ? 2 : 1))
            && (ocol_r < {1'b0, w_eff_r});
  end

  // Advance the counters
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    if (accept && push) begin
      in_col_nxt = in_last ? '0 : in_col_r + 1'b1;
      if (is_pix && in_last) begin
        in_row_nxt = in_row_r + 1'b1;
      end
      if (is_pix) begin
        pend_nxt = emit ? pend_r : pend_inc;
      end else begin
        pend_nxt = pend_r - 1'b1;
      end
      if (emit) begin
        if (out_frame_end) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          pend_nxt    = '0;
        end else if (out_row_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Build the command
  always_comb begin
    cmd.value         = is_pix ? in_chan.pixel_in : '0;
    cmd.col           = in_col_r;
    cmd.emit          = emit;
    cmd.tag.mode5     = mode5_r;
    cmd.tag.interior  = interior;
    cmd.tag.row_end   = out_row_end;
    cmd.tag.frame_end = out_frame_end;
  end

  // Command queue towards the back end
  always_ff @(posedge clk) begin
    if (accept && push) begin
      q_mem_r[q_wr_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (accept && push) begin
        q_wr_r <= q_wr_r + 1'b1;
      end
      if (cmd_pop) begin
        q_rd_r <= q_rd_r + 1'b1;
      end
      q_cnt_r <= q_cnt_r + (mf2_pkg::QP_W + 1)'(accept && push)
                         - (mf2_pkg::QP_W + 1)'(cmd_pop);
    end
  end

  assign cmd_valid = (q_cnt_r != '0);
  assign cmd_head  = q_mem_r[q_rd_r];
endmodule

// File: rtl/mf2_median.sv
// Rank-select median over the window: compare matrix, rank count, select.
// Three registered stages plus an output register. Depends on mf2_pkg.
module mf2_median (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  mf2_pkg::win_t  in_win,
  input  mf2_pkg::tag_t  in_tag,
  output logic           res_valid,
  output mf2_pkg::res_t  res
);
  logic                  v0_r, v1_r, v2_r;
  mf2_pkg::win_t         win0_r, win1_r, win2_r;
  mf2_pkg::tag_t         tag0_r, tag1_r, tag2_r;
  logic [mf2_pkg::WIN_SIZE-1:0][mf2_pkg::WIN_SIZE-1:0] lt, lt1_r;
  logic [mf2_pkg::WIN_SIZE-1:0][mf2_pkg::RANK_W-1:0]  cnt, cnt2_r;
  mf2_pkg::pix_t         med, pick;
  logic [mf2_pkg::RANK_W-1:0] rank;

  // Pairwise order, ties broken by tap position
  always_comb begin
    for (int i = 0; i < mf2_pkg::WIN_SIZE; i++) begin
      for (int j = 0; j < mf2_pkg::WIN_SIZE; j++) begin
        lt[i][j] = mf2_pkg::in_sub(j, tag0_r.mode5)
                && ((win0_r[j] < win0_r[i]) || ((win0_r[j] == win0_r[i]) && (j < i)));
      end
    end
  end

  // Rank of each tap
  always_comb begin
    for (int i = 0; i < mf2_pkg::WIN_SIZE; i++) begin
      cnt[i] = mf2_pkg::RANK_W'($countones(lt1_r[i]));
    end
  end

  // Pick the tap of middle rank, or the centre on the border
  always_comb begin
    rank = tag2_r.mode5 ? mf2_pkg::RANK_W'(mf2_pkg::RANK5) : mf2_pkg::RANK_W'(mf2_pkg::RANK3);
    med  = '0;
    for (int i = 0; i < mf2_pkg::WIN_SIZE; i++) begin
      if (mf2_pkg::in_sub(i, tag2_r.mode5) && (cnt2_r[i] == rank)) begin
        med = med | win2_r[i];
      end
    end
    if (tag2_r.interior) begin
      pick = med;
    end else if (tag2_r.mode5) begin
      pick = win2_r[mf2_pkg::CENTRE5];
    end else begin
      pick = win2_r[mf2_pkg::CENTRE3];
    end
  end

  always_ff @(posedge clk) begin
    win0_r <= in_win;
    tag0_r <= in_tag;
    win1_r <= win0_r;
    tag1_r <= tag0_r;
    lt1_r  <= lt;
    win2_r <= win1_r;
    tag2_r <= tag1_r;
    cnt2_r <= cnt;
    res.pixel     <= pick;
    res.row_end   <= tag2_r.row_end;
    res.frame_end <= tag2_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v0_r      <= in_valid;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      res_valid <= v2_r;
    end
  end
endmodule

// File: rtl/mf2_back.sv
// Back end: line store, window registers, median pipeline and result FIFO.
// Depends on mf2_pkg, mf2_stream_if, mf2_ram, mf2_median.
module mf2_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  mf2_pkg::cmd_t cmd_head,
  output logic          cmd_pop,
  mf2_out_if.source     out_chan
);
  localparam int LS_W = mf2_pkg::HIST_ROWS * mf2_pkg::PIX_W;

  logic                  s1_valid_r;
  mf2_pkg::cmd_t         s1_cmd_r;
  logic [LS_W-1:0]       ls_rdata, ls_wdata;
  mf2_pkg::win_t         win_r, win_nxt;
  logic                  med_valid;
  mf2_pkg::res_t         med_res;

  mf2_pkg::res_t         of_mem_r [mf2_pkg::ODEPTH];
  logic [mf2_pkg::OP_W-1:0] of_wr_r, of_rd_r;
  logic [mf2_pkg::OP_W:0]   of_cnt_r, infl_r;
  logic                  out_take;

  // Issue a command only when its result is sure of a FIFO slot
  assign cmd_pop = cmd_valid
                && (!cmd_head.emit
                    || (({1'b0, infl_r} + {1'b0, of_cnt_r}) < (mf2_pkg::OP_W + 2)'(mf2_pkg::ODEPTH)));

  always_ff @(posedge clk) begin
    s1_cmd_r <= cmd_head;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= cmd_pop;
    end
  end

  mf2_ram #(
    .WIDTH (LS_W),
    .DEPTH (mf2_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_cmd_r.col),
    .wdata (ls_wdata),
    .raddr (cmd_head.col),
    .rdata (ls_rdata)
  );

  // Move the column history up by one row
  assign ls_wdata = {ls_rdata[LS_W-mf2_pkg::PIX_W-1:0], s1_cmd_r.value};

  // Shift the window left and load the new column
  always_comb begin
    for (int i = 0; i < mf2_pkg::WIN_SIDE; i++) begin
      for (int j = 0; j < mf2_pkg::WIN_SIDE - 1; j++) begin
        win_nxt[i * mf2_pkg::WIN_SIDE + j] = win_r[i * mf2_pkg::WIN_SIDE + j + 1];
      end
    end
    for (int i = 0; i < mf2_pkg::HIST_ROWS; i++) begin
      win_nxt[i * mf2_pkg::WIN_SIDE + mf2_pkg::WIN_SIDE - 1] =
        ls_rdata[(mf2_pkg::HIST_ROWS - 1 - i) * mf2_pkg::PIX_W +: mf2_pkg::PIX_W];
    end
    win_nxt[mf2_pkg::WIN_SIZE - 1] = s1_cmd_r.value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  mf2_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid_r && s1_cmd_r.emit),
    .in_win    (win_nxt),
    .in_tag    (s1_cmd_r.tag),
    .res_valid (med_valid),
    .res       (med_res)
  );

  // Result FIFO
  assign out_take = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (med_valid) begin
      of_mem_r[of_wr_r] <= med_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      of_wr_r  <= '0;
      of_rd_r  <= '0;
      of_cnt_r <= '0;
      infl_r   <= '0;
    end else begin
      if (med_valid) begin
        of_wr_r <= of_wr_r + 1'b1;
      end
      if (out_take) begin
        of_rd_r <= of_rd_r + 1'b1;
      end
      of_cnt_r <= of_cnt_r + (mf2_pkg::OP_W + 1)'(med_valid)
                           - (mf2_pkg::OP_W + 1)'(out_take);
      infl_r   <= infl_r + (mf2_pkg::OP_W + 1)'(cmd_pop && cmd_head.emit)
                         - (mf2_pkg::OP_W + 1)'(med_valid);
    end
  end

  assign out_chan.valid     = (of_cnt_r != '0);
  assign out_chan.pixel_out = of_mem_r[of_rd_r].pixel;
  assign out_chan.row_end   = of_mem_r[of_rd_r].row_end;
  assign out_chan.frame_end = of_mem_r[of_rd_r].frame_end;
endmodule

// File: rtl/median_filter_2d.sv
// Top level of the streaming 3x3 / 5x5 median filter for packed RGB pixels.
// Depends on mf2_pkg, mf2_stream_if, mf2_front, mf2_back.
//
// Usage:
//   in_chan  : valid/ready stream of items; operation selects pixel or drain,
//              pixel_in carries a 24-bit RGB word in raster order.
//   out_chan : valid/ready stream of results: pixel_out, row_end, frame_end.
//   cfg_*    : write port for image_width (0), image_height (1) and
//              window_mode (2); write only while the block is idle.
// Throughput is one item per cycle while the command queue has room. A pixel
// leaves once R rows and R pixels of the frame behind it have arrived (R = 1
// or 2); after the last pixel of a frame, each drain item pushes one waiting
// pixel out. After acceptance a result passes the command queue, the line
// store read, the window shift, three median stages and the result FIFO.
// Reset is synchronous: counters, queues and the window clear, the
// registers return to 640 x 480, 3x3. The line store needs no clearing.
// When the receiver stalls, results collect in an eight-entry FIFO and the
// input keeps accepting until the four-entry command queue fills.
module median_filter_2d (
  input  logic                           clk,
  input  logic                           rst_n,
  mf2_in_if.sink                         in_chan,
  mf2_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [mf2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf2_pkg::CFG_DATA_W-1:0] cfg_data
);
  logic          cmd_valid, cmd_pop;
  mf2_pkg::cmd_t cmd_head;

  mf2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head)
  );

  mf2_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .out_chan  (out_chan)
  );
endmodule

// File: rtl/mf2_checker.sv
// Port-level checks on the result stream of the median filter, with the bind.
// Depends on median_filter_2d and mf2_pkg.
module mf2_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [mf2_pkg::PIX_W-1:0] out_pixel,
  input logic                      out_row_end,
  input logic                      out_frame_end
);
  // Reset empties the result stream
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The last pixel of a frame is also the last of its row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn under stall");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_pixel) && $stable(out_row_end) && $stable(out_frame_end)))
    else $error("result changed under stall");
endmodule

bind median_filter_2d mf2_checker u_mf2_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_pixel     (out_chan.pixel_out),
  .out_row_end   (out_chan.row_end),
  .out_frame_end (out_chan.frame_end)
);

// File: verif/mf2_checker.sv
`timescale 1ns / 1ps
// Scoreboard for median_filter_2d: watches the input, result and config ports,
// predicts every result and compares it. Depends on mf2_pkg and mf2_stream_if.
module mf2_scoreboard (
  input  logic                           clk,
  input  logic                           rst_n,
  mf2_in_if                              in_mon,
  mf2_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [mf2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mf2_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             results_seen,
  output int                             frames_seen
);
  import mf2_pkg::*;

  // Predictor state: column history, window and raster positions
  pix_t        col_hist [HIST_ROWS][MAX_WIDTH];
  pix_t        win      [WIN_SIDE][WIN_SIDE];
  int unsigned in_col, in_row, out_col, out_row;
  logic [WIDTH_CFG_W-1:0] width_reg;
  logic [ROW_W-1:0]       height_reg;
  logic                   mode_reg;

  res_t expected_pixels[$];

  task automatic report(input string what, input res_t got, input res_t want);
    $display("%0t mismatch %s: got pix=%06h re=%0b fe=%0b, want pix=%06h re=%0b fe=%0b",
             $realtime, what, got.pixel, got.row_end, got.frame_end,
             want.pixel, want.row_end, want.frame_end);
    fail_count++;
  endtask

  function automatic void clear_state();
    foreach (col_hist[i, j]) col_hist[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  // Shift one pixel into the window and the column history
  function automatic void shift_in(input pix_t v, input int unsigned col);
    if (col >= MAX_WIDTH) col = 0;
    for (int i = 0; i < WIN_SIDE; i++)
      for (int j = 0; j < WIN_SIDE - 1; j++) win[i][j] = win[i][j+1];
    for (int i = 0; i < HIST_ROWS; i++) win[i][WIN_SIDE-1] = col_hist[i][col];
    win[WIN_SIDE-1][WIN_SIDE-1] = v;
    for (int i = 0; i < HIST_ROWS - 1; i++) col_hist[i][col] = col_hist[i+1][col];
    col_hist[HIST_ROWS-1][col] = v;
  endfunction

  // Rank-n/2 element of the bottom-right (2r+1)^2 window
  function automatic pix_t window_median(input int unsigned r);
    pix_t vals[$];
    pix_t v;
    int   base, k;
    base = WIN_SIDE - 1 - 2 * r;
    for (int i = base; i < WIN_SIDE; i++)
      for (int j = base; j < WIN_SIDE; j++) vals.push_back(win[i][j]);
    for (int i = 1; i < vals.size(); i++) begin
      v = vals[i];
      k = i;
      while (k > 0 && vals[k-1] > v) begin
        vals[k] = vals[k-1];
        k--;
      end
      vals[k] = v;
    end
    return vals[vals.size() / 2];
  endfunction

  function automatic res_t emit_pixel(input int unsigned w, h, r);
    res_t        res;
    int unsigned c;
    c = WIN_SIDE - 1 - r;
    res.pixel     = win[c][c];
    res.row_end   = (out_col + 1 >= w);
    res.frame_end = res.row_end && (out_row + 1 >= h);
    if (out_row >= r && out_row + r < h && out_col >= r && out_col + r < w)
      res.pixel = window_median(r);
    if (res.frame_end) begin
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    end else if (res.row_end) begin
      out_col = 0; out_row++;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  // Advance the filter by one item; returns 1 when a result is due
  function automatic bit filter_step(input op_t op, input pix_t px, output res_t res);
    int unsigned w, h, r, d, in_idx, out_idx;
    bit          complete;
    w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : ((width_reg < MIN_DIM) ? MIN_DIM : width_reg);
    h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT :
        ((height_reg < MIN_DIM) ? MIN_DIM : height_reg);
    r = mode_reg ? 2 : 1;
    d = r * w + r;
    complete = (in_row >= h);
    out_idx = out_row * w + out_col;
    if (op == OP_PIXEL && !complete) begin
      shift_in(px, in_col);
      if (in_col + 1 >= w) begin
        in_col = 0; in_row++;
      end else begin
        in_col++;
      end
      in_idx = (in_row >= h) ? h * w : in_row * w + in_col;
      if (in_idx > out_idx && in_idx - out_idx > d) begin
        res = emit_pixel(w, h, r);
        return 1;
      end
      return 0;
    end
    in_idx = h * w;
    if (complete && in_idx > out_idx) begin
      shift_in('0, in_col);
      in_col = (in_col + 1 >= w) ? 0 : in_col + 1;
      res = emit_pixel(w, h, r);
      return 1;
    end
    return 0;
  endfunction

  // Compare results, then predict from the accepted item, then track config
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      clear_state();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      mode_reg   = 1'b0;
      expected_pixels.delete();
      fail_count   = 0;
      results_seen = 0;
      frames_seen  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.pixel     = out_mon.pixel_out;
        got.row_end   = out_mon.row_end;
        got.frame_end = out_mon.frame_end;
        results_seen++;
        if (got.frame_end) frames_seen++;
        if (expected_pixels.size() == 0) begin
          report("unexpected result", got, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (got.pixel !== want.pixel) report("pixel_out", got, want);
          if (got.row_end !== want.row_end) report("row_end", got, want);
          if (got.frame_end !== want.frame_end) report("frame_end", got, want);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (filter_step(in_mon.operation, in_mon.pixel_in, want))
          expected_pixels.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_reg  = cfg_data[WIDTH_CFG_W-1:0];
          CFG_HEIGHT: height_reg = cfg_data[ROW_W-1:0];
          CFG_MODE:   mode_reg   = cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for median_filter_2d: clock, reset, stimulus and verdict.
// Depends on mf2_pkg, mf2_stream_if, median_filter_2d and mf2_scoreboard.
module tb;
  import mf2_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 1650;

  logic clk, rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int   fail_count, pending, results_seen, frames_seen;
  int   burst_left, items_sent;
  bit   hold_req;

  mf2_in_if  in_chan();
  mf2_out_if out_chan();

  median_filter_2d u_top (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  mf2_scoreboard u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .frames_seen(frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop the run if nothing moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("** median_filter_2d: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int cyc, held;
    cyc = 0;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        held++;
        if (held >= HOLD_CYCLES) hold_req = 0;
      end else begin
        held = 0;
        case ((cyc / 250) % 4)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 99) < 75);
          2: out_chan.ready <= (cyc % 5 != 0);
          default: out_chan.ready <= ($urandom_range(0, 99) < 40);
        endcase
      end
    end
  end

  function automatic int unsigned clamp_width(input int unsigned raw);
    return (raw > MAX_WIDTH) ? MAX_WIDTH : ((raw < MIN_DIM) ? MIN_DIM : raw);
  endfunction

  function automatic int unsigned clamp_height(input int unsigned raw);
    return (raw > MAX_HEIGHT) ? MAX_HEIGHT : ((raw < MIN_DIM) ? MIN_DIM : raw);
  endfunction

  function automatic pix_t pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return ($urandom_range(0, 1)) ? 24'h800000 : 24'h7FFFFF;
      3: return ($urandom_range(0, 1)) ? 24'h0000FF : 24'hFF0000;
      default: return pix_t'($urandom);
    endcase
  endfunction

  // Offer one item in bursts with random gaps; returns at a falling edge
  task automatic send(input op_t op, input pix_t px);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.pixel_in  <= px;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid, wait for every result, then let the pipeline settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_config(input int raw_w, input int raw_h, input int mode);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= CFG_DATA_W'(raw_w);
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= CFG_DATA_W'(raw_h);
    @(negedge clk);
    cfg_index <= CFG_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One frame: pixels with stray drains, then the tail flush and spare drains
  task automatic send_frame(input int raw_w, input int raw_h, input int mode,
                            input bit directed);
    pix_t        pattern[25];
    int unsigned w, h, r;
    pattern = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h0000FF,
                24'hFF0000, 24'h00FF00, 24'h000001, 24'hFFFFFE, 24'h010000,
                24'h808080, 24'h808080, 24'h808080, 24'hAAAAAA, 24'h555555,
                24'h00FFFF, 24'hFFFF00, 24'h000100, 24'hFEFFFF, 24'h7F7F7F,
                24'hFFFFFF, 24'h000000, 24'h123456, 24'hEDCBA9, 24'h808081};
    w = clamp_width(raw_w);
    h = clamp_height(raw_h);
    r = mode ? 2 : 1;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 99) < 6) send(OP_DRAIN, pix_t'($urandom));
      send(OP_PIXEL, (directed && i < 25) ? pattern[i] : pick_pixel());
    end
    // a pixel item while the tail waits acts as a drain
    for (int i = 0; i < r * w + r; i++)
      send(($urandom_range(0, 99) < 70) ? OP_DRAIN : OP_PIXEL, pick_pixel());
    repeat ($urandom_range(0, 2)) send(OP_DRAIN, pick_pixel());
  endtask

  initial begin
    int rw, rh, md;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_WIDTH;
    cfg_data          = '0;
    in_chan.valid     = 1'b0;
    in_chan.operation = OP_PIXEL;
    in_chan.pixel_in  = '0;
    hold_req          = 0;
    burst_left        = 0;
    items_sent        = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: smallest frame in both window sizes, then sizes below range
    write_config(5, 5, 0);
    send_frame(5, 5, 0, 1);
    wait_idle();
    write_config(0, 0, 1);
    send_frame(0, 0, 1, 1);
    wait_idle();
    write_config(3, 2, 0);
    send_frame(3, 2, 0, 0);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering
    write_config(40, 6, 1);
    hold_req = 1;
    send_frame(40, 6, 1, 0);
    wait_idle();

    // One wider frame in the large window
    write_config(60, 5, 1);
    send_frame(60, 5, 1, 0);
    wait_idle();

    // Random geometries, mostly small
    while (items_sent < ITEM_TARGET) begin
      rw = $urandom_range(5, 14);
      rh = $urandom_range(5, 9);
      md = $urandom_range(0, 1);
      write_config(rw, rh, md);
      repeat ($urandom_range(1, 2)) send_frame(rw, rh, md, 0);
      wait_idle();
    end

    repeat (20) @(negedge clk);
    $display("covered %0d input items, %0d results in %0d frames", items_sent,
             results_seen, frames_seen);
    $display("both window sizes, widths 5 to 60, sizes below range, one long stall");
    if (fail_count == 0)
      $display("** median_filter_2d: PASSED **");
    else
      $display("** median_filter_2d: FAILED **");
    $finish;
  end

endmodule
